// ===== src/wkht_pkg.sv =====
// wkht_pkg: shared constants, codes and structs of the wait-key hash table.
// No dependencies; used by every module under src.
package wkht_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 31;
    localparam int KIND_W = 3;
    localparam int HASH_LO_A = 2;
    localparam int HASH_LO_B = 12;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 40;
    localparam logic signed [VAL_W-1:0] WAKE_ALL_ARG = 32'sh7FFF_FFFF;

    localparam logic OP_WAIT = 1'b0;
    localparam logic OP_WAKE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_BLOCK = 3'd1,
        KIND_COUNT = 3'd2,
        KIND_ALL   = 3'd3,
        KIND_FAULT = 3'd4,
        KIND_FULL  = 3'd5
    } kind_t;

    typedef struct packed {
        logic                    op;
        logic [KEY_W-1:0]        key;
        logic                    read_ok;
        logic signed [VAL_W-1:0] user_value;
        logic signed [VAL_W-1:0] argument;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [5:0]        slot;
        logic [CNT_W-1:0]  wake_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture request, start probe at home slot
        logic read;    // read slot at probe pointer
        logic step;    // advance probe pointer
        logic finish;  // commit result (and claim) into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;      // current probe settles the request
        logic out_busy;  // output register full and not drained this cycle
    } sts_t;

endpackage

// ===== src/wkht_ctrl.sv =====
// wkht_ctrl: probe sequencer of the wait-key hash table.
// Depends on wkht_pkg (cmd_t, sts_t).
module wkht_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wkht_pkg::sts_t sts,
    output wkht_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!sts.done)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
                else if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/wkht_datapath.sv =====
// wkht_datapath: key memory, used bits, probe pointer, decision logic and
// output register of the wait-key hash table. Depends on wkht_pkg.
module wkht_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  wkht_pkg::cmd_t    cmd,
    output wkht_pkg::sts_t    sts,
    input  wkht_pkg::item_t   item,
    output logic              out_valid,
    input  logic              out_ready,
    output wkht_pkg::result_t result
);

    logic [wkht_pkg::KEY_W-1:0]  key_mem [wkht_pkg::SLOTS];
    logic [wkht_pkg::SLOTS-1:0]  used_reg;

    wkht_pkg::item_t             item_reg;
    logic [wkht_pkg::SLOT_W-1:0] ptr_reg;
    logic [wkht_pkg::SLOT_W-1:0] cnt_reg;
    logic [wkht_pkg::KEY_W-1:0]  rd_key_reg;
    logic                        rd_used_reg;

    logic                        out_valid_reg;
    wkht_pkg::result_t           out_reg;

    logic [wkht_pkg::SLOT_W-1:0] home;
    logic [wkht_pkg::SLOT_W-1:0] ptr_inc;
    logic                        hit;
    logic                        last;
    logic                        dec_done;
    logic                        dec_claim;
    wkht_pkg::kind_t             dec_kind;
    logic                        dec_slot_en;
    logic [wkht_pkg::CNT_W-1:0]  dec_count;

    // home = ((key >> 2) ^ (key >> 12)) mod SLOTS
    assign home = item.key[wkht_pkg::HASH_LO_A +: wkht_pkg::SLOT_W]
                ^ item.key[wkht_pkg::HASH_LO_B +: wkht_pkg::SLOT_W];

    assign ptr_inc = (ptr_reg == wkht_pkg::SLOT_W'(wkht_pkg::SLOTS - 1))
                   ? '0 : ptr_reg + 1'b1;

    assign hit  = rd_used_reg && (rd_key_reg == item_reg.key);
    assign last = (cnt_reg == wkht_pkg::SLOT_W'(wkht_pkg::SLOTS - 1));

    always_comb
    begin
        dec_done    = 1'b1;
        dec_claim   = 1'b0;
        dec_kind    = wkht_pkg::KIND_NONE;
        dec_slot_en = 1'b0;
        dec_count   = '0;
        if (item_reg.op == wkht_pkg::OP_WAIT)
        begin
            if (!item_reg.read_ok)
            begin
                dec_kind = wkht_pkg::KIND_FAULT;
            end
            else if (item_reg.user_value != item_reg.argument)
            begin
                dec_kind = wkht_pkg::KIND_NONE;
            end
            else if (hit || !rd_used_reg)
            begin
                dec_kind    = wkht_pkg::KIND_BLOCK;
                dec_slot_en = 1'b1;
                dec_claim   = !rd_used_reg;
            end
            else if (last)
            begin
                dec_kind = wkht_pkg::KIND_FULL;
            end
            else
            begin
                dec_done = 1'b0;
            end
        end
        else
        begin
            if (hit)
            begin
                dec_slot_en = 1'b1;
                if (item_reg.argument == wkht_pkg::WAKE_ALL_ARG)
                begin
                    dec_kind = wkht_pkg::KIND_ALL;
                end
                else
                begin
                    dec_kind  = wkht_pkg::KIND_COUNT;
                    dec_count = item_reg.argument[wkht_pkg::VAL_W-1]
                              ? '0 : item_reg.argument[wkht_pkg::CNT_W-1:0];
                end
            end
            else if (!rd_used_reg || last)
            begin
                dec_kind = wkht_pkg::KIND_NONE;
            end
            else
            begin
                dec_done = 1'b0;
            end
        end
    end

    assign sts.done     = dec_done;
    assign sts.out_busy = out_valid_reg && !out_ready;

    // key memory: one read or one write per cycle, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_key_reg <= key_mem[ptr_reg];
        end
        if (cmd.finish && dec_claim)
        begin
            key_mem[ptr_reg] <= item_reg.key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.finish)
        begin
            out_reg.result_kind <= dec_kind;
            out_reg.slot        <= dec_slot_en ? 6'(ptr_reg) : '0;
            out_reg.wake_count  <= dec_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            rd_used_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg <= home;
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                ptr_reg <= ptr_inc;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.read)
            begin
                rd_used_reg <= used_reg[ptr_reg];
            end
            if (cmd.finish && dec_claim)
            begin
                used_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

`ifndef SYNTHESIS
    // a claim only takes a free slot
    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && dec_claim) |-> !rd_used_reg)
        else $error("claim of a used slot");

    // a claimed slot reads as used afterwards
    a_claim_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && dec_claim) |=> used_reg[$past(ptr_reg)])
        else $error("claimed slot not marked used");

    // full is only reported after the whole table was probed
    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && dec_kind == wkht_pkg::KIND_FULL) |-> last)
        else $error("full reported before last probe");

    // a pending result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result register overrun");
`endif

endmodule

// ===== src/wait_key_hash_table.sv =====
// wait_key_hash_table: top level of the wait-key hash table.
// Depends on wkht_pkg, wkht_ctrl and wkht_datapath.
//
// Usage:
//   Requests come in on the s_axis channel, one beat per request (wait or
//   wake, selected by s_axis_tuser). Each request gives exactly one result
//   beat on the m_axis channel, in request order.
//   The table has 64 slots of 64-bit keys, probed linearly from the home
//   slot (key[7:2] ^ key[17:12]) with wrap; each slot probe is a
//   registered key memory read, then a compare.
//   A result is registered when a probe settles the request, at the latest
//   after all 64 slots have been probed. Fault and value-mismatch waits
//   settle at the first probe. The next request can be taken in the cycle
//   after a result is registered.
//   Reset clears all used bits at once; the table is ready right after
//   reset with no clearing pass. Keys of unused slots are never compared.
//   A stalled receiver holds the result in the output register; the block
//   still takes the next request and probes, and waits before
//   registering its result until the previous one has been taken.
module wait_key_hash_table
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [63:0] key, [64] read_ok, [96:65] user_value, [128:97] argument,
    // [135:129] zero
    input  logic [wkht_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] slot, [36:6] wake_count, [39:37] zero
    output logic [wkht_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [2:0] result_kind
    output logic [wkht_pkg::KIND_W-1:0]      m_axis_tuser
);

    wkht_pkg::cmd_t    cmd;
    wkht_pkg::sts_t    sts;
    wkht_pkg::item_t   item;
    wkht_pkg::result_t result;
    logic              in_ready;

    // unpack request beat
    assign item.op         = s_axis_tuser;
    assign item.key        = s_axis_tdata[63:0];
    assign item.read_ok    = s_axis_tdata[64];
    assign item.user_value = s_axis_tdata[96:65];
    assign item.argument   = s_axis_tdata[128:97];

    assign s_axis_tready = in_ready;

    wkht_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wkht_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .item      (item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // pack result beat
    assign m_axis_tdata = {3'b000, result.wake_count, result.slot};
    assign m_axis_tuser = result.result_kind;

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the wait-key hash table (wait_key_hash_table).
// Depends on wkht_pkg and the RTL under src. It keeps its own copy of the slot table,
// predicts every result beat, and checks the beats in order.
module testbench;

    import wkht_pkg::*;

    // Run limits. The slowest request probes all 64 slots, and the receiver
    // can add a long stall on top of that.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS  = 760;
    localparam int POOL_SIZE     = 56;   // keeps the table short of full until the fill test

    // Receiver stall patterns
    localparam int RX_ALWAYS = 0;   // never stalls
    localparam int RX_CHOPPY = 1;   // short random stalls, with ready low about a quarter of the time
    localparam int RX_LONG   = 2;   // mostly ready, with an occasional long stall

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;

    wait_key_hash_table dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the slot table, advanced once per accepted request
    logic [KEY_W-1:0] table_key [SLOTS];
    logic             table_used[SLOTS];
    int               used_slots = 0;

    result_t          expected_results[$];   // one entry per request still in flight
    int               err_count   = 0;
    int               cycle_count = 0;

    // Traffic shaping, changed between tests
    int               tx_max_burst = 1;
    int               tx_max_gap   = 0;      // 0: valid stays high back to back
    int               burst_left   = 1;
    int               rx_mode      = RX_ALWAYS;
    int               rx_hold      = 0;

    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake or a lost beat ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Table model. Home slot is key[7:2] ^ key[17:12]; linear probe with wrap.
    // A wait claims the first free slot it meets unless the key is already
    // there; a wake only searches and gives up at the first free slot.
    function automatic result_t predict_table_result(input item_t req);
        result_t res;
        int      home;
        int      s;
        int      i;
        bit      settled;
        res     = '0;
        settled = 1'b0;
        home    = int'(((req.key >> HASH_LO_A) ^ (req.key >> HASH_LO_B)) % SLOTS);
        if (req.op == OP_WAIT)
        begin
            if (!req.read_ok)
                res.result_kind = KIND_FAULT;
            else if (req.user_value != req.argument)
                res.result_kind = KIND_NONE;
            else
            begin
                res.result_kind = KIND_FULL;
                for (i = 0; i < SLOTS && !settled; i++)
                begin
                    s = (home + i) % SLOTS;
                    if (!table_used[s])
                    begin
                        table_used[s]   = 1'b1;
                        table_key[s]    = req.key;
                        used_slots++;
                        res.result_kind = KIND_BLOCK;
                        res.slot        = s[5:0];
                        settled         = 1'b1;
                    end
                    else if (table_key[s] == req.key)
                    begin
                        res.result_kind = KIND_BLOCK;
                        res.slot        = s[5:0];
                        settled         = 1'b1;
                    end
                end
            end
        end
        else
        begin
            res.result_kind = KIND_NONE;
            for (i = 0; i < SLOTS && !settled; i++)
            begin
                s = (home + i) % SLOTS;
                if (!table_used[s])
                    settled = 1'b1;          // free slot: miss
                else if (table_key[s] == req.key)
                begin
                    settled  = 1'b1;
                    res.slot = s[5:0];
                    if (req.argument == WAKE_ALL_ARG)
                        res.result_kind = KIND_ALL;
                    else
                    begin
                        res.result_kind = KIND_COUNT;
                        // negative counts clamp to zero
                        res.wake_count  = req.argument[VAL_W-1] ? '0 : req.argument[CNT_W-1:0];
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic item_t make_request(input logic op, input logic [KEY_W-1:0] key,
                                           input logic read_ok,
                                           input logic [VAL_W-1:0] user_value,
                                           input logic [VAL_W-1:0] argument);
        item_t req;
        req.op         = op;
        req.key        = key;
        req.read_ok    = read_ok;
        req.user_value = user_value;
        req.argument   = argument;
        return req;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    // Wake counts: weighted toward the edges (wake all, most negative, the largest count)
    function automatic logic [VAL_W-1:0] pick_wake_arg();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = WAKE_ALL_ARG;
            1:       v = 32'h8000_0000;
            2:       v = $urandom | 32'h8000_0000;
            3:       v = WAKE_ALL_ARG - 1;
            default: v = $urandom & 32'h7FFF_FFFF;
        endcase
        return v;
    endfunction

    // Send one request beat; the expectation is recorded at the accepting edge.
    // Must be called at a rising edge. Valid is left high unless a gap follows.
    task automatic send_request(input item_t req);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {7'd0, req.argument, req.user_value, req.read_ok, req.key};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(predict_table_result(req));
        if (tx_max_gap > 0)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = $urandom_range(1, tx_max_gap);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, tx_max_burst);
            end
        end
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_traffic(input int max_burst, input int max_gap, input int rx);
        tx_max_burst = max_burst;
        tx_max_gap   = max_gap;
        burst_left   = 1;
        rx_mode      = rx;
    endtask

    // Receiver: stall pattern plus in-order check of each result beat.
    // Values are sampled at the edge, before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat: result_kind %0d slot %0d wake_count %0d",
                       m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[36:6]);
                err_count++;
            end
            else
            begin
                if (m_axis_tuser !== expected_results[0].result_kind)
                begin
                    $error("result_kind: expected %0d actual %0d",
                           expected_results[0].result_kind, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[5:0] !== expected_results[0].slot)
                begin
                    $error("slot: expected %0d actual %0d",
                           expected_results[0].slot, m_axis_tdata[5:0]);
                    err_count++;
                end
                if (m_axis_tdata[36:6] !== expected_results[0].wake_count)
                begin
                    $error("wake_count: expected %0d actual %0d",
                           expected_results[0].wake_count, m_axis_tdata[36:6]);
                    err_count++;
                end
                void'(expected_results.pop_front());
            end
        end

        if (rx_hold > 0)
        begin
            rx_hold--;
        end
        else
        begin
            case (rx_mode)
                RX_CHOPPY:
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_LONG:
                    if ($urandom_range(0, 7) == 0)
                    begin
                        m_axis_tready <= 1'b0;
                        rx_hold       = $urandom_range(3, 20);
                    end
                    else
                        m_axis_tready <= 1'b1;
                default:
                    m_axis_tready <= 1'b1;
            endcase
        end
    end

    // ---------------- tests ----------------

    // Failed reads and value mismatches never touch the table
    task automatic test_fault_and_mismatch();
        set_traffic(1, 0, RX_ALWAYS);
        send_request(make_request(OP_WAIT, '1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_request(OP_WAIT, '0, 1'b0, 32'h8000_0000, 32'h0000_0001));
        send_request(make_request(OP_WAIT, '0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_request(OP_WAIT, '1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF));
    endtask

    // Key 0 matches the initial contents of the model's key table, but an unused slot
    // must never give a hit
    task automatic test_wake_empty();
        send_request(make_request(OP_WAKE, '0, 1'b1, '0, 32'd5));
        send_request(make_request(OP_WAKE, '1, 1'b0, '0, WAKE_ALL_ARG));
    endtask

    // Claims, repeat hits, a collision, and a probe that wraps past slot 63
    task automatic test_wait_claim();
        set_traffic(2, 3, RX_CHOPPY);
        send_request(make_request(OP_WAIT, 64'h0, 1'b1, 32'h8000_0000, 32'h8000_0000));
        send_request(make_request(OP_WAIT, 64'h0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_request(OP_WAIT, 64'h100, 1'b1, 32'h1234_5678, 32'h1234_5678));
        send_request(make_request(OP_WAIT, 64'hFC, 1'b1, '0, '0));          // home 63
        send_request(make_request(OP_WAIT, 64'h1FC, 1'b1, '1, '1));         // wraps
        send_request(make_request(OP_WAIT, '1, 1'b1, 32'h5555_AAAA, 32'h5555_AAAA));
    endtask

    // Wake all, count clamping, the largest count, and a miss after a run
    task automatic test_wake_hits();
        send_request(make_request(OP_WAKE, 64'h1FC, 1'b0, '0, WAKE_ALL_ARG));
        send_request(make_request(OP_WAKE, '1, 1'b1, '1, 32'h8000_0000));
        send_request(make_request(OP_WAKE, 64'h0, 1'b0, '0, 32'h0));
        send_request(make_request(OP_WAKE, 64'h0, 1'b0, '0, 32'h7FFF_FFFE));
        send_request(make_request(OP_WAKE, 64'h100, 1'b0, '0, 32'hFFFF_FFFF));
        send_request(make_request(OP_WAKE, 64'h100, 1'b0, '0, 32'd1));
        send_request(make_request(OP_WAKE, 64'h2FC, 1'b0, '0, 32'd3));      // runs into a free slot
    endtask

    // Mixed traffic over a pool of keys. Keys come in clusters sharing a home
    // slot so probe runs get long; one cluster sits at home 63 to force wrap.
    task automatic test_random_traffic();
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] uv;
        int               pick;
        int               n;
        for (n = 0; n < POOL_SIZE; n++)
        begin
            if (n % 4 == 0)
            begin
                base = fresh_key();
                if (n == 0)
                    base[7:2] = ~base[17:12];
            end
            key_pool[n]       = fresh_key();
            key_pool[n][17:0] = base[17:0];
        end

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // four stretches: no idling, bursts with short stalls, long stalls, mixed
            if (n == 0)
                set_traffic(1, 0, RX_ALWAYS);
            else if (n == RANDOM_ITEMS / 4)
                set_traffic(8, 4, RX_CHOPPY);
            else if (n == RANDOM_ITEMS / 2)
            begin
                wait_for_results();
                set_traffic(3, 8, RX_LONG);
            end
            else if (n == 3 * RANDOM_ITEMS / 4)
                set_traffic(12, 2, RX_CHOPPY);

            key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            uv   = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_request(make_request(OP_WAIT, key, 1'b1, uv, uv));
            else if (pick < 55)
                send_request(make_request(OP_WAIT, pick[0] ? key : fresh_key(), 1'b1, uv,
                                          uv ^ $urandom_range(1, 32'hFFFF_FFFF)));
            else if (pick < 62)
                send_request(make_request(OP_WAIT, pick[0] ? key : fresh_key(), 1'b0, uv,
                                          pick[1] ? uv : $urandom));
            else if (pick < 92)
                send_request(make_request(OP_WAKE, key, 1'($urandom_range(0, 1)), uv,
                                          pick_wake_arg()));
            else
                send_request(make_request(OP_WAKE, fresh_key(), 1'($urandom_range(0, 1)), uv,
                                          pick_wake_arg()));
        end
    endtask

    // Fill every slot, then check full, a wake that visits all 64 slots, and hits
    task automatic test_table_full();
        logic [VAL_W-1:0] uv;
        int               n;
        set_traffic(4, 3, RX_CHOPPY);
        while (used_slots < SLOTS)
        begin
            uv = $urandom;
            send_request(make_request(OP_WAIT, fresh_key(), 1'b1, uv, uv));
        end
        for (n = 0; n < 3; n++)
        begin
            uv = $urandom;
            send_request(make_request(OP_WAIT, fresh_key(), 1'b1, uv, uv));
            send_request(make_request(OP_WAKE, fresh_key(), 1'b1, uv, pick_wake_arg()));
        end
        send_request(make_request(OP_WAIT, key_pool[0], 1'b1, 32'd7, 32'd7));
        send_request(make_request(OP_WAKE, key_pool[POOL_SIZE - 1], 1'b0, '0, 32'd9));
        send_request(make_request(OP_WAKE, 64'hFC, 1'b0, '0, WAKE_ALL_ARG));
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            table_key[i]  = '0;
            table_used[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fault_and_mismatch();
        test_wake_empty();
        test_wait_claim();
        test_wake_hits();
        test_random_traffic();
        test_table_full();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
